>>> rtl/lde_pkg.sv
// Shared types and constants for the line delta span encoder.
// No dependencies; imported by every module of the block.
package lde_pkg;

  localparam int LINE_BYTES = 16;
  localparam int HALF_BYTES = 8;
  localparam int POS_W      = 4;

  localparam logic [7:0] UNCHANGED_CODE = 8'hFF;

  typedef logic [7:0]       byte_t;
  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic  any;
    pos_t  first;
    pos_t  last;
    byte_t header;
  } span_t;

endpackage

>>> rtl/lde_lane.sv
// One byte lane: XOR of the previous and next line byte and its change flag.
// Depends on lde_pkg.
module lde_lane
  import lde_pkg::*;
(
  input  byte_t old_byte,
  input  byte_t new_byte,
  output byte_t diff_byte,
  output logic  changed
);

  assign diff_byte = old_byte ^ new_byte;
  assign changed   = |diff_byte;

endmodule

>>> rtl/lde_merge.sv
// Merge of the lane change flags into the span of the line and its header.
// Depends on lde_pkg.
module lde_merge
  import lde_pkg::*;
(
  input  logic [LINE_BYTES-1:0] changed,
  output span_t                 span
);

  function automatic pos_t encode(input logic [LINE_BYTES-1:0] onehot);
    pos_t code;
    code = '0;
    for (int b = 0; b < POS_W; b++) begin
      for (int i = 0; i < LINE_BYTES; i++) begin
        if (((i >> b) & 1) == 1) begin
          code[b] = code[b] | onehot[i];
        end
      end
    end
    return code;
  endfunction

  logic [LINE_BYTES-1:0] rev;
  logic [LINE_BYTES-1:0] low_iso;
  logic [LINE_BYTES-1:0] high_iso;
  pos_t                  first;
  pos_t                  last;
  pos_t                  rev_pos;

  always_comb begin
    for (int i = 0; i < LINE_BYTES; i++) begin
      rev[i] = changed[LINE_BYTES-1-i];
    end
  end

  assign low_iso  = changed & (~changed + {{(LINE_BYTES-1){1'b0}}, 1'b1});
  assign high_iso = rev & (~rev + {{(LINE_BYTES-1){1'b0}}, 1'b1});
  assign first    = encode(low_iso);
  assign rev_pos  = encode(high_iso);
  assign last     = ~rev_pos;

  always_comb begin
    span.any    = |changed;
    span.first  = first;
    span.last   = last;
    span.header = span.any ? {first, pos_t'(last - first)} : UNCHANGED_CODE;
  end

endmodule

>>> rtl/line_delta_span_encoder_top.sv
// Top level of the line delta span encoder: byte lanes, span merge and the
// output serializer. Depends on lde_pkg, lde_lane and lde_merge.
//
// Usage: the in_ channel takes one word per line, the old and new 16-byte
// lines as four 64-bit halves. Sixteen lanes XOR the bytes in parallel and
// the merge finds the first and last changed byte; the word is captured in
// the line register in the cycle it is accepted.
// The out_ channel gives one byte per word: the header, then the XOR bytes
// of the span; out_last_of_line marks the final byte of each line. An
// unchanged line gives the single byte 0xFF.
// The header is on out_ in the cycle after the input word is taken. A line
// leaves as its header alone if unchanged, else as its header and then the
// span bytes (at most 17 bytes), set by the single-byte output port. The next input
// word is taken in the cycle the last byte of the current line leaves, so
// lines follow each other without gaps.
// Reset clears the line register's valid state; nothing else is flushed.
// When the receiver stalls, the current byte holds on out_ and in_ready
// stays low until the line's last byte is taken.
module line_delta_span_encoder_top
  import lde_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_old_bytes_low,
  input  logic [63:0] in_old_bytes_high,
  input  logic [63:0] in_new_bytes_low,
  input  logic [63:0] in_new_bytes_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last_of_line
);

  byte_t                 diff [LINE_BYTES];
  logic [LINE_BYTES-1:0] changed;
  span_t                 span;

  for (genvar i = 0; i < LINE_BYTES; i++) begin : g_lane
    byte_t old_b;
    byte_t new_b;
    if (i < HALF_BYTES) begin : g_low
      assign old_b = in_old_bytes_low[8*i +: 8];
      assign new_b = in_new_bytes_low[8*i +: 8];
    end else begin : g_high
      assign old_b = in_old_bytes_high[8*(i-HALF_BYTES) +: 8];
      assign new_b = in_new_bytes_high[8*(i-HALF_BYTES) +: 8];
    end
    lde_lane u_lane (
      .old_byte  (old_b),
      .new_byte  (new_b),
      .diff_byte (diff[i]),
      .changed   (changed[i])
    );
  end

  lde_merge u_merge (
    .changed (changed),
    .span    (span)
  );

  logic  busy_r,  busy_nxt;
  logic  hdr_r,   hdr_nxt;
  pos_t  pos_r,   pos_nxt;
  span_t span_r;
  byte_t diff_r [LINE_BYTES];

  logic in_fire;
  logic out_fire;

  assign out_valid        = busy_r;
  assign out_byte         = hdr_r ? span_r.header : diff_r[pos_r];
  assign out_last_of_line = hdr_r ? ~span_r.any : (pos_r == span_r.last);

  assign out_fire = out_valid & out_ready;
  assign in_ready = ~busy_r | (out_ready & out_last_of_line);
  assign in_fire  = in_valid & in_ready;

  always_comb begin
    busy_nxt = busy_r;
    hdr_nxt  = hdr_r;
    pos_nxt  = pos_r;
    if (out_fire) begin
      if (out_last_of_line) begin
        busy_nxt = 1'b0;
      end else if (hdr_r) begin
        hdr_nxt = 1'b0;
        pos_nxt = span_r.first;
      end else begin
        pos_nxt = pos_r + pos_t'(1);
      end
    end
    if (in_fire) begin
      busy_nxt = 1'b1;
      hdr_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      hdr_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      hdr_r  <= hdr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (in_fire) begin
      span_r <= span;
      diff_r <= diff;
    end
  end

endmodule
